/* hw/rtl/pcalu_pkg.sv */
// shared types, operation codes and helpers for the p-code integer alu
package pcalu_pkg;

	localparam int MAX_BYTES  = 8;
	localparam int WORD_W     = 8 * MAX_BYTES;
	localparam int DIV_STAGES = WORD_W;

	localparam logic [5:0] OP_COPY        = 6'd0;
	localparam logic [5:0] OP_ADD         = 6'd1;
	localparam logic [5:0] OP_SUB         = 6'd2;
	localparam logic [5:0] OP_MULT        = 6'd3;
	localparam logic [5:0] OP_DIV         = 6'd4;
	localparam logic [5:0] OP_REM         = 6'd5;
	localparam logic [5:0] OP_SDIV        = 6'd6;
	localparam logic [5:0] OP_SREM        = 6'd7;
	localparam logic [5:0] OP_OR          = 6'd8;
	localparam logic [5:0] OP_XOR         = 6'd9;
	localparam logic [5:0] OP_AND         = 6'd10;
	localparam logic [5:0] OP_LEFT        = 6'd11;
	localparam logic [5:0] OP_RIGHT       = 6'd12;
	localparam logic [5:0] OP_SRIGHT      = 6'd13;
	localparam logic [5:0] OP_EQUAL       = 6'd14;
	localparam logic [5:0] OP_NOTEQUAL    = 6'd15;
	localparam logic [5:0] OP_LESS        = 6'd16;
	localparam logic [5:0] OP_LESSEQUAL   = 6'd17;
	localparam logic [5:0] OP_CARRY       = 6'd18;
	localparam logic [5:0] OP_SLESS       = 6'd19;
	localparam logic [5:0] OP_SLESSEQUAL  = 6'd20;
	localparam logic [5:0] OP_SCARRY      = 6'd21;
	localparam logic [5:0] OP_SBORROW     = 6'd22;
	localparam logic [5:0] OP_BOOL_OR     = 6'd23;
	localparam logic [5:0] OP_BOOL_XOR    = 6'd24;
	localparam logic [5:0] OP_BOOL_AND    = 6'd25;
	localparam logic [5:0] OP_BOOL_NEGATE = 6'd26;
	localparam logic [5:0] OP_PIECE       = 6'd27;
	localparam logic [5:0] OP_SUBPIECE    = 6'd28;
	localparam logic [5:0] OP_ZEXT        = 6'd29;
	localparam logic [5:0] OP_SEXT        = 6'd30;
	localparam logic [5:0] OP_2COMP       = 6'd31;
	localparam logic [5:0] OP_INVERT      = 6'd32;

	localparam logic [1:0] SEL_SIMPLE = 2'd0;
	localparam logic [1:0] SEL_MULT   = 2'd1;
	localparam logic [1:0] SEL_QUO    = 2'd2;
	localparam logic [1:0] SEL_REM    = 2'd3;

	// what travels beside the divider
	typedef struct packed {
		logic [1:0]        sel;
		logic              negate;
		logic [WORD_W-1:0] r_simple;
		logic [WORD_W-1:0] pp_ll;
		logic [31:0]       pp_x1;
		logic [31:0]       pp_x2;
		logic [3:0]        rb;
		logic              dz;
		logic              err;
	} sband_t;

	function automatic logic [WORD_W-1:0] bytes_mask(input logic [3:0] n);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [3:0] clamp_bytes(input logic [3:0] v);
		if (v == 4'd0)
			return 4'd1;
		if (v > 4'(MAX_BYTES))
			return 4'(MAX_BYTES);
		return v;
	endfunction

endpackage

/* hw/rtl/pcalu_div.sv */
// pipelined restoring divider, one quotient bit per stage, sideband carried along
module pcalu_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic [pcalu_pkg::WORD_W-1:0] dividend,
	input  logic [pcalu_pkg::WORD_W-1:0] divisor,
	input  pcalu_pkg::sband_t        in_sb,
	output logic                     out_vld,
	output logic [pcalu_pkg::WORD_W-1:0] quotient,
	output logic [pcalu_pkg::WORD_W-1:0] remainder,
	output pcalu_pkg::sband_t        out_sb
);
	import pcalu_pkg::*;

	logic [WORD_W-1:0] rem_s [DIV_STAGES];
	logic [WORD_W-1:0] quo_s [DIV_STAGES];
	logic [WORD_W-1:0] dvs_s [DIV_STAGES];
	sband_t            sb_s  [DIV_STAGES];
	logic              vld_s [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			logic [WORD_W-1:0] rem_in, quo_in, dvs_in;
			sband_t            sb_in;
			logic              vld_in;
			logic [WORD_W:0]   trial, diff;
			logic              take;

			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign quo_in = dividend;
				assign dvs_in = divisor;
				assign sb_in  = in_sb;
				assign vld_in = in_vld;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign quo_in = quo_s[k-1];
				assign dvs_in = dvs_s[k-1];
				assign sb_in  = sb_s[k-1];
				assign vld_in = vld_s[k-1];
			end

			assign trial = {rem_in, quo_in[WORD_W-1]};
			assign diff  = trial - {1'b0, dvs_in};
			assign take  = !diff[WORD_W];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
					quo_s[k] <= {quo_in[WORD_W-2:0], take};
					dvs_s[k] <= dvs_in;
					sb_s[k]  <= sb_in;
				end
			end
		end
	endgenerate

	assign out_vld   = vld_s[DIV_STAGES-1];
	assign quotient  = quo_s[DIV_STAGES-1];
	assign remainder = rem_s[DIV_STAGES-1];
	assign out_sb    = sb_s[DIV_STAGES-1];

endmodule

/* hw/rtl/pcode_integer_alu.sv */
// p-code integer alu top level: decode, operations, multiply and divide pipeline
// every operation passes the input register, the 64-stage divider pipeline and the output register
// throughput: one item per cycle while the output is not stalled
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset clears only the valid bits; data registers are not reset
module pcode_integer_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  req_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic [3:0]  a_bytes,
	input  logic [3:0]  b_bytes,
	input  logic [3:0]  out_bytes,
	input  logic [2:0]  byte_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result,
	output logic [3:0]  result_bytes,
	output logic        div_by_zero,
	output logic        operand_error
);
	import pcalu_pkg::*;

	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// decode
	logic [3:0]        na, nb;
	logic [WORD_W-1:0] ma, a_m, b_m, sa_c, sb_c, ua_c, ub_c;
	logic [5:0]        sidx;
	logic              nega_c, negb_c, signed_op;

	always_comb begin
		na     = clamp_bytes(a_bytes);
		nb     = clamp_bytes(b_bytes);
		ma     = bytes_mask(na);
		a_m    = operand_a & ma;
		b_m    = operand_b & bytes_mask(nb);
		sidx   = {3'(na - 4'd1), 3'b111};
		nega_c = a_m[sidx];
		negb_c = b_m[sidx];
		sa_c   = a_m | (nega_c ? ~ma : '0);
		sb_c   = (b_m & ma) | (negb_c ? ~ma : '0);
		signed_op = (req_type == OP_SDIV) || (req_type == OP_SREM);
		ua_c   = (signed_op && nega_c) ? ((-a_m) & ma) : a_m;
		ub_c   = (signed_op && negb_c) ? ((-b_m) & ma) : b_m;
	end

	logic              vld_s1, nega_s1, negb_s1;
	logic [5:0]        op_s1;
	logic [3:0]        na_s1, nb_s1, no_s1;
	logic [2:0]        off_s1;
	logic [WORD_W-1:0] a_s1, b_s1, sa_s1, sb_s1, ua_s1, ub_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= req_type;
			na_s1   <= na;
			nb_s1   <= nb;
			no_s1   <= clamp_bytes(out_bytes);
			off_s1  <= byte_offset;
			a_s1    <= a_m;
			b_s1    <= b_m;
			sa_s1   <= sa_c;
			sb_s1   <= sb_c;
			ua_s1   <= ua_c;
			ub_s1   <= ub_c;
			nega_s1 <= nega_c;
			negb_s1 <= negb_c;
		end
	end

	function automatic logic [5:0] sidx_s(input logic [3:0] n);
		return {3'(n - 4'd1), 3'b111};
	endfunction

	// simple operations and multiply partial products
	sband_t            sb;
	logic [WORD_W-1:0] sum, dif, shl, shr, sar;
	logic              big_shift, b_zero;

	always_comb begin
		sum       = a_s1 + b_s1;
		dif       = a_s1 - b_s1;
		big_shift = b_s1 >= WORD_W'({na_s1, 3'b000});
		shl       = a_s1 << b_s1[5:0];
		shr       = a_s1 >> b_s1[5:0];
		sar       = WORD_W'($signed(sa_s1) >>> b_s1[5:0]);
		b_zero    = (b_s1 == '0);

		sb          = '0;
		sb.sel      = SEL_SIMPLE;
		sb.rb       = na_s1;
		sb.pp_ll    = a_s1[31:0] * b_s1[31:0];
		sb.pp_x1    = 32'(a_s1[31:0] * b_s1[63:32]);
		sb.pp_x2    = 32'(a_s1[63:32] * b_s1[31:0]);

		case (op_s1)
			OP_COPY:   sb.r_simple = a_s1;
			OP_ADD:    sb.r_simple = sum;
			OP_SUB:    sb.r_simple = dif;
			OP_MULT:   sb.sel = SEL_MULT;
			OP_DIV, OP_REM, OP_SDIV, OP_SREM: begin
				if (b_zero) begin
					sb.dz = 1'b1;
				end else begin
					sb.sel = (op_s1 == OP_DIV || op_s1 == OP_SDIV) ? SEL_QUO : SEL_REM;
					if (op_s1 == OP_SDIV)
						sb.negate = nega_s1 != negb_s1;
					else if (op_s1 == OP_SREM)
						sb.negate = nega_s1;
				end
			end
			OP_OR:     sb.r_simple = a_s1 | b_s1;
			OP_XOR:    sb.r_simple = a_s1 ^ b_s1;
			OP_AND:    sb.r_simple = a_s1 & b_s1;
			OP_LEFT:   sb.r_simple = big_shift ? '0 : shl;
			OP_RIGHT:  sb.r_simple = big_shift ? '0 : shr;
			OP_SRIGHT: sb.r_simple = big_shift ? (nega_s1 ? '1 : '0) : (nega_s1 ? sar : shr);
			OP_EQUAL:      sb.r_simple = WORD_W'(a_s1 == b_s1);
			OP_NOTEQUAL:   sb.r_simple = WORD_W'(a_s1 != b_s1);
			OP_LESS:       sb.r_simple = WORD_W'(a_s1 < b_s1);
			OP_LESSEQUAL:  sb.r_simple = WORD_W'(a_s1 <= b_s1);
			OP_CARRY:      sb.r_simple = WORD_W'((sum & bytes_mask(na_s1)) < a_s1);
			OP_SLESS:      sb.r_simple = WORD_W'($signed(sa_s1) < $signed(sb_s1));
			OP_SLESSEQUAL: sb.r_simple = WORD_W'(!($signed(sb_s1) < $signed(sa_s1)));
			OP_SCARRY:
				sb.r_simple = WORD_W'((~(a_s1 ^ b_s1) & (a_s1 ^ sum)) >> (sidx_s(na_s1)) & 1'b1);
			OP_SBORROW:
				sb.r_simple = WORD_W'(((a_s1 ^ b_s1) & (a_s1 ^ dif)) >> (sidx_s(na_s1)) & 1'b1);
			OP_BOOL_OR, OP_BOOL_XOR, OP_BOOL_AND, OP_BOOL_NEGATE: begin
				sb.rb = 4'd1;
				if (na_s1 != 4'd1 || a_s1 > 1 ||
				    (op_s1 != OP_BOOL_NEGATE && (nb_s1 != 4'd1 || b_s1 > 1))) begin
					sb.err = 1'b1;
				end else begin
					case (op_s1)
						OP_BOOL_OR:  sb.r_simple = a_s1 | b_s1;
						OP_BOOL_XOR: sb.r_simple = a_s1 ^ b_s1;
						OP_BOOL_AND: sb.r_simple = a_s1 & b_s1;
						default:     sb.r_simple = a_s1 ^ WORD_W'(1);
					endcase
				end
			end
			OP_PIECE: begin
				if (5'(na_s1) + 5'(nb_s1) > 5'(MAX_BYTES)) begin
					sb.rb  = 4'(MAX_BYTES);
					sb.err = 1'b1;
				end else begin
					sb.rb       = na_s1 + nb_s1;
					sb.r_simple = (a_s1 << {nb_s1, 3'b000}) | b_s1;
				end
			end
			OP_SUBPIECE: begin
				sb.rb       = no_s1;
				sb.r_simple = (4'(off_s1) >= na_s1) ? '0 : (a_s1 >> {off_s1, 3'b000});
			end
			OP_ZEXT:   begin sb.rb = no_s1; sb.r_simple = a_s1; end
			OP_SEXT:   begin sb.rb = no_s1; sb.r_simple = sa_s1; end
			OP_2COMP:  sb.r_simple = -a_s1;
			OP_INVERT: sb.r_simple = ~a_s1;
			default:   sb.rb = 4'd1;
		endcase

		// size check for two-operand arithmetic, bitwise logic and compares
		if (op_s1 inside {[OP_ADD:OP_AND], [OP_EQUAL:OP_SBORROW]} && na_s1 != nb_s1) begin
			sb.sel      = SEL_SIMPLE;
			sb.negate   = 1'b0;
			sb.r_simple = '0;
			sb.dz       = 1'b0;
			sb.err      = 1'b1;
		end
		if (op_s1 inside {[OP_EQUAL:OP_SBORROW]})
			sb.rb = 4'd1;
	end

	logic              vld_d;
	logic [WORD_W-1:0] quo_d, rem_d;
	sband_t            sb_d;

	pcalu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (vld_s1),
		.dividend  (ua_s1),
		.divisor   (ub_s1),
		.in_sb     (sb),
		.out_vld   (vld_d),
		.quotient  (quo_d),
		.remainder (rem_d),
		.out_sb    (sb_d)
	);

	// final select, sign fix and size mask
	logic [WORD_W-1:0] r_fin, qr;

	always_comb begin
		qr = (sb_d.sel == SEL_QUO) ? quo_d : rem_d;
		case (sb_d.sel)
			SEL_MULT: r_fin = sb_d.pp_ll + {sb_d.pp_x1 + sb_d.pp_x2, 32'b0};
			SEL_QUO, SEL_REM: r_fin = sb_d.negate ? -qr : qr;
			default:  r_fin = sb_d.r_simple;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result        <= r_fin & bytes_mask(sb_d.rb);
			result_bytes  <= sb_d.rb;
			div_by_zero   <= sb_d.dz;
			operand_error <= sb_d.err;
		end
	end

endmodule
